// File: rtl/ipsu_pkg.sv
// Package: request kinds, opcodes, error codes and sizing constants of the step unit.
package ipsu_pkg;

    localparam int MEM_WORDS_DEF = 65536;

    localparam logic [1:0] REQ_LOAD    = 2'd0;
    localparam logic [1:0] REQ_READ    = 2'd1;
    localparam logic [1:0] REQ_RESTART = 2'd2;
    localparam logic [1:0] REQ_STEP    = 2'd3;

    localparam logic [6:0] OP_ADD  = 7'd1;
    localparam logic [6:0] OP_MUL  = 7'd2;
    localparam logic [6:0] OP_IN   = 7'd3;
    localparam logic [6:0] OP_OUT  = 7'd4;
    localparam logic [6:0] OP_JT   = 7'd5;
    localparam logic [6:0] OP_JF   = 7'd6;
    localparam logic [6:0] OP_LT   = 7'd7;
    localparam logic [6:0] OP_EQ   = 7'd8;
    localparam logic [6:0] OP_ARB  = 7'd9;
    localparam logic [6:0] OP_HALT = 7'd99;

    localparam logic [3:0] MODE_POS = 4'd0;
    localparam logic [3:0] MODE_IMM = 4'd1;
    localparam logic [3:0] MODE_REL = 4'd2;

    localparam logic [1:0] NO_DEST = 2'd3;

    localparam logic [1:0] ERR_NONE   = 2'd0;
    localparam logic [1:0] ERR_OPCODE = 2'd1;
    localparam logic [1:0] ERR_MODE   = 2'd2;
    localparam logic [1:0] ERR_ADDR   = 2'd3;

    // Word mod 100000 = 32 * ((word >> 5) mod 3125) + word[4:0]
    localparam logic [11:0] FOLD_2P20  = 12'd1701;      // 2^20 mod 3125
    localparam logic [11:0] FOLD_2P40  = 12'd2776;      // 2^40 mod 3125
    localparam logic [23:0] RECIP_3125 = 24'd10995117;  // 2^35 / 3125, rounded up
    localparam logic [11:0] DIV_3125   = 12'd3125;
    localparam logic [17:0] RECIP_100  = 18'd167773;    // 2^24 / 100, rounded up
    localparam logic [7:0]  RECIP_10   = 8'd205;        // 2^11 / 10, rounded up

    typedef logic [63:0] word_t;

endpackage

// File: rtl/intcode_processor_step_unit.sv
// Top level: word-addressed step processor with relative base and one word store with a read and a write port.
// Sequence: load and restart go from idle straight to FIN, an in-range read via RDW; a decoded step
//   runs fetch, reduction of the word modulo 100000 (FOLD1, FOLD2, RECQ, REMD), digit split
//   (DEC1-DEC3), decode, PARAM and PRAW per parameter plus OPND for a memory read, execute,
//   then MUL0-MUL2 to multiply. Stopped or counter out of range: straight to FIN; negative word: WORD, then FIN.
// Throughput: one transaction at a time; the next is taken once the block is back in idle.
// Reset: aresetn (synchronous, active low) clears control state, then a clearing pass
//   writes zero to every word, during which s_tready stays low.
module intcode_processor_step_unit
    import ipsu_pkg::*;
#(
    parameter int MEM_WORDS = MEM_WORDS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [87:0] s_tdata,   // address[15:0], value[79:16], value_offered[80], zero fill
    input  logic [1:0]  s_tuser,   // req_type[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata    // out_valid[0], out_value[64:1], input_taken[65],
                                   // waiting_input[66], halted[67], error_code[69:68]
);

    localparam int AW = $clog2(MEM_WORDS);
    localparam logic [63:0] MEM_LIMIT = 64'(MEM_WORDS);
    localparam logic [AW-1:0] LAST_ADDR = AW'(MEM_WORDS - 1);

    // Sequencer states
    localparam logic [4:0] ST_CLR   = 5'd0;
    localparam logic [4:0] ST_IDLE  = 5'd1;
    localparam logic [4:0] ST_RDW   = 5'd2;
    localparam logic [4:0] ST_WORD  = 5'd3;
    localparam logic [4:0] ST_FOLD1 = 5'd4;
    localparam logic [4:0] ST_DEC1  = 5'd5;
    localparam logic [4:0] ST_DEC2  = 5'd6;
    localparam logic [4:0] ST_DEC3  = 5'd7;
    localparam logic [4:0] ST_CHECK = 5'd8;
    localparam logic [4:0] ST_PARAM = 5'd9;
    localparam logic [4:0] ST_PRAW  = 5'd10;
    localparam logic [4:0] ST_OPND  = 5'd11;
    localparam logic [4:0] ST_EXEC  = 5'd12;
    localparam logic [4:0] ST_MUL0  = 5'd13;
    localparam logic [4:0] ST_MUL1  = 5'd14;
    localparam logic [4:0] ST_MUL2  = 5'd15;
    localparam logic [4:0] ST_FIN   = 5'd16;
    localparam logic [4:0] ST_FOLD2 = 5'd17;
    localparam logic [4:0] ST_RECQ  = 5'd18;
    localparam logic [4:0] ST_REMD  = 5'd19;

    // Word store: one write port, one registered read port
    word_t           mem [MEM_WORDS];
    word_t           mem_rdata_reg;
    logic            mem_we;
    logic [AW-1:0]   mem_waddr;
    logic [AW-1:0]   mem_raddr;
    word_t           mem_wdata;

    // Control state
    logic [4:0]      state_reg, state_next;
    logic [AW-1:0]   clr_addr_reg, clr_addr_next;
    logic [AW:0]     pc_reg, pc_next;
    word_t           rb_reg, rb_next;
    logic            stopped_reg, stopped_next;
    logic [1:0]      fault_reg, fault_next;
    logic            m_tvalid_reg, m_tvalid_next;

    // Datapath registers
    logic [1:0]      req_reg, req_next;
    word_t           val_reg, val_next;
    logic            offered_reg, offered_next;
    logic [62:0]     word_reg, word_next;
    logic [16:0]     rem_reg, rem_next;
    logic [31:0]     fold_reg, fold_next;
    logic [11:0]     quo_reg, quo_next;
    logic [9:0]      q_reg, q_next;
    logic [6:0]      q2_reg, q2_next;
    logic [6:0]      op_reg, op_next;
    logic [3:0]      modes_reg [3];
    logic [3:0]      modes_next [3];
    logic [1:0]      nparam_reg, nparam_next;
    logic [1:0]      wr_idx_reg, wr_idx_next;
    logic [1:0]      k_reg, k_next;
    word_t           opnd_reg [3];
    word_t           opnd_next [3];
    word_t           acc_reg, acc_next;
    logic            res_valid_reg, res_valid_next;
    word_t           res_value_reg, res_value_next;
    logic            res_taken_reg, res_taken_next;
    logic            res_wait_reg, res_wait_next;
    logic [71:0]     m_tdata_reg, m_tdata_next;

    // Input fields
    logic [15:0]     in_addr;
    word_t           in_addr64;
    logic            s_fire;

    // Shared 32x32 multiplier
    logic [31:0]     mul_a, mul_b;
    logic [63:0]     mul_p;

    // Decode helpers
    logic [31:0]     fold1_sum;
    logic [22:0]     fold2_sum;
    logic [46:0]     recip_p;
    logic [22:0]     rem3125;
    logic [34:0]     dec1_p;
    logic [17:0]     dec2_p;
    logic [14:0]     dec3_p;
    logic [3:0]      q3;
    logic [AW+1:0]   param_addr;
    logic [AW:0]     pc_adv;
    word_t           op_addr;
    logic [3:0]      cur_mode;
    logic            mode_bad;
    logic            jump_take;

    assign in_addr   = s_tdata[15:0];
    assign in_addr64 = 64'(in_addr);
    assign s_tready  = (state_reg == ST_IDLE);
    assign s_fire    = s_tvalid && s_tready;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    always_comb begin
        case (state_reg)
            ST_MUL1: begin
                mul_a = opnd_reg[0][31:0];
                mul_b = opnd_reg[1][63:32];
            end
            ST_MUL2: begin
                mul_a = opnd_reg[0][63:32];
                mul_b = opnd_reg[1][31:0];
            end
            default: begin
                mul_a = opnd_reg[0][31:0];
                mul_b = opnd_reg[1][31:0];
            end
        endcase
    end
    assign mul_p = 64'(mul_a) * 64'(mul_b);

    // Fold (word >> 5) down modulo 3125, then finish with a reciprocal quotient
    assign fold1_sum  = 32'(word_reg[62:45]) * 32'(FOLD_2P40)
                      + 32'(word_reg[44:25]) * 32'(FOLD_2P20)
                      + 32'(word_reg[24:5]);
    assign fold2_sum  = 23'(fold_reg[31:20]) * 23'(FOLD_2P20) + 23'(fold_reg[19:0]);
    assign recip_p    = 47'(fold_reg[22:0]) * 47'(RECIP_3125);
    assign rem3125    = fold_reg[22:0] - 23'(quo_reg) * 23'(DIV_3125);
    assign dec1_p     = 35'(rem_reg) * 35'(RECIP_100);
    assign dec2_p     = 18'(q_reg) * 18'(RECIP_10);
    assign dec3_p     = 15'(q2_reg) * 15'(RECIP_10);
    assign q3         = dec3_p[14:11];
    assign param_addr = (AW+2)'(pc_reg) + (AW+2)'(k_reg) + (AW+2)'(1);
    assign pc_adv     = pc_reg + (AW+1)'(nparam_reg) + (AW+1)'(1);
    assign cur_mode   = modes_reg[k_reg];
    assign op_addr    = (cur_mode == MODE_REL) ? mem_rdata_reg + rb_reg : mem_rdata_reg;
    assign jump_take  = (op_reg == OP_JT) == (opnd_reg[0] != '0);

    always_comb begin
        mode_bad = 1'b0;
        for (int i = 0; i < 3; i++) begin
            if (2'(i) < nparam_reg) begin
                if (modes_reg[i] > MODE_REL) begin
                    mode_bad = 1'b1;
                end
                if (2'(i) == wr_idx_reg && modes_reg[i] == MODE_IMM) begin
                    mode_bad = 1'b1;
                end
            end
        end
    end

    always_comb begin
        state_next     = state_reg;
        clr_addr_next  = clr_addr_reg;
        pc_next        = pc_reg;
        rb_next        = rb_reg;
        stopped_next   = stopped_reg;
        fault_next     = fault_reg;
        m_tvalid_next  = m_tvalid_reg;
        req_next       = req_reg;
        val_next       = val_reg;
        offered_next   = offered_reg;
        word_next      = word_reg;
        rem_next       = rem_reg;
        fold_next      = fold_reg;
        quo_next       = quo_reg;
        q_next         = q_reg;
        q2_next        = q2_reg;
        op_next        = op_reg;
        modes_next     = modes_reg;
        nparam_next    = nparam_reg;
        wr_idx_next    = wr_idx_reg;
        k_next         = k_reg;
        opnd_next      = opnd_reg;
        acc_next       = acc_reg;
        res_valid_next = res_valid_reg;
        res_value_next = res_value_reg;
        res_taken_next = res_taken_reg;
        res_wait_next  = res_wait_reg;
        m_tdata_next   = m_tdata_reg;
        mem_we         = 1'b0;
        mem_waddr      = opnd_reg[2][AW-1:0];
        mem_wdata      = '0;
        mem_raddr      = pc_reg[AW-1:0];

        // Drop the output transaction once taken
        if (m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_CLR: begin
                // Zero the words in turn, from address zero up, after reset
                mem_we    = 1'b1;
                mem_waddr = clr_addr_reg;
                clr_addr_next = clr_addr_reg + AW'(1);
                if (clr_addr_reg == LAST_ADDR) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_fire) begin
                    req_next       = s_tuser;
                    val_next       = s_tdata[79:16];
                    offered_next   = s_tdata[80];
                    res_valid_next = 1'b0;
                    res_value_next = '0;
                    res_taken_next = 1'b0;
                    res_wait_next  = 1'b0;
                    state_next     = ST_FIN;
                    case (s_tuser)
                        REQ_LOAD: begin
                            if (in_addr64 < MEM_LIMIT) begin
                                mem_we    = 1'b1;
                                mem_waddr = in_addr64[AW-1:0];
                                mem_wdata = s_tdata[79:16];
                            end
                        end
                        REQ_READ: begin
                            mem_raddr = in_addr64[AW-1:0];
                            if (in_addr64 < MEM_LIMIT) begin
                                state_next = ST_RDW;
                            end
                        end
                        REQ_RESTART: begin
                            pc_next      = '0;
                            rb_next      = '0;
                            stopped_next = 1'b0;
                            fault_next   = ERR_NONE;
                        end
                        default: begin
                            if (!stopped_reg) begin
                                if (64'(pc_reg) >= MEM_LIMIT) begin
                                    stopped_next = 1'b1;
                                    fault_next   = ERR_ADDR;
                                end else begin
                                    state_next = ST_WORD;
                                end
                            end
                        end
                    endcase
                end
            end
            ST_RDW: begin
                res_value_next = mem_rdata_reg;
                state_next     = ST_FIN;
            end
            ST_WORD: begin
                if (mem_rdata_reg[63]) begin
                    stopped_next = 1'b1;
                    fault_next   = ERR_OPCODE;
                    state_next   = ST_FIN;
                end else begin
                    word_next  = mem_rdata_reg[62:0];
                    state_next = ST_FOLD1;
                end
            end
            ST_FOLD1: begin
                fold_next  = fold1_sum;
                state_next = ST_FOLD2;
            end
            ST_FOLD2: begin
                fold_next  = 32'(fold2_sum);
                state_next = ST_RECQ;
            end
            ST_RECQ: begin
                quo_next   = recip_p[46:35];
                state_next = ST_REMD;
            end
            ST_REMD: begin
                // Rebuild word mod 100000 from the mod-3125 part and the low five bits
                rem_next   = {rem3125[11:0], word_reg[4:0]};
                state_next = ST_DEC1;
            end
            ST_DEC1: begin
                q_next     = dec1_p[33:24];
                state_next = ST_DEC2;
            end
            ST_DEC2: begin
                op_next    = 7'(rem_reg - 17'(17'(q_reg) * 17'd100));
                q2_next    = dec2_p[17:11];
                state_next = ST_DEC3;
            end
            ST_DEC3: begin
                modes_next[0] = 4'(q_reg - 10'(10'(q2_reg) * 10'd10));
                modes_next[1] = 4'(q2_reg - 7'(7'(q3) * 7'd10));
                modes_next[2] = q3;
                state_next    = ST_CHECK;
            end
            ST_CHECK: begin
                k_next     = '0;
                state_next = ST_FIN;
                case (op_reg)
                    OP_ADD, OP_MUL, OP_LT, OP_EQ: begin
                        nparam_next = 2'd3;
                        wr_idx_next = 2'd2;
                        state_next  = ST_PARAM;
                    end
                    OP_IN: begin
                        nparam_next = 2'd1;
                        wr_idx_next = 2'd0;
                        state_next  = ST_PARAM;
                    end
                    OP_OUT, OP_ARB: begin
                        nparam_next = 2'd1;
                        wr_idx_next = NO_DEST;
                        state_next  = ST_PARAM;
                    end
                    OP_JT, OP_JF: begin
                        nparam_next = 2'd2;
                        wr_idx_next = NO_DEST;
                        state_next  = ST_PARAM;
                    end
                    OP_HALT: begin
                        stopped_next = 1'b1;
                    end
                    default: begin
                        stopped_next = 1'b1;
                        fault_next   = ERR_OPCODE;
                    end
                endcase
            end
            ST_PARAM: begin
                // Mode check sees the operand count latched last cycle
                if (k_reg == '0 && mode_bad) begin
                    stopped_next = 1'b1;
                    fault_next   = ERR_MODE;
                    state_next   = ST_FIN;
                end else if (64'(param_addr) >= MEM_LIMIT) begin
                    stopped_next = 1'b1;
                    fault_next   = ERR_ADDR;
                    state_next   = ST_FIN;
                end else begin
                    mem_raddr  = param_addr[AW-1:0];
                    state_next = ST_PRAW;
                end
            end
            ST_PRAW: begin
                mem_raddr = op_addr[AW-1:0];
                if (cur_mode == MODE_IMM) begin
                    opnd_next[k_reg] = mem_rdata_reg;
                    k_next     = k_reg + 2'd1;
                    state_next = (k_reg + 2'd1 == nparam_reg) ? ST_EXEC : ST_PARAM;
                end else if (op_addr >= MEM_LIMIT) begin
                    stopped_next = 1'b1;
                    fault_next   = ERR_ADDR;
                    state_next   = ST_FIN;
                end else if (k_reg == wr_idx_reg) begin
                    opnd_next[k_reg] = op_addr;
                    k_next     = k_reg + 2'd1;
                    state_next = (k_reg + 2'd1 == nparam_reg) ? ST_EXEC : ST_PARAM;
                end else begin
                    state_next = ST_OPND;
                end
            end
            ST_OPND: begin
                opnd_next[k_reg] = mem_rdata_reg;
                k_next     = k_reg + 2'd1;
                state_next = (k_reg + 2'd1 == nparam_reg) ? ST_EXEC : ST_PARAM;
            end
            ST_EXEC: begin
                state_next = ST_FIN;
                pc_next    = pc_adv;
                case (op_reg)
                    OP_ADD: begin
                        mem_we    = 1'b1;
                        mem_wdata = opnd_reg[0] + opnd_reg[1];
                    end
                    OP_MUL: begin
                        pc_next    = pc_reg;
                        state_next = ST_MUL0;
                    end
                    OP_IN: begin
                        if (offered_reg) begin
                            mem_we         = 1'b1;
                            mem_waddr      = opnd_reg[0][AW-1:0];
                            mem_wdata      = val_reg;
                            res_taken_next = 1'b1;
                        end else begin
                            pc_next       = pc_reg;
                            res_wait_next = 1'b1;
                        end
                    end
                    OP_OUT: begin
                        res_valid_next = 1'b1;
                        res_value_next = opnd_reg[0];
                    end
                    OP_JT, OP_JF: begin
                        if (jump_take) begin
                            if (opnd_reg[1] >= MEM_LIMIT) begin
                                pc_next      = pc_reg;
                                stopped_next = 1'b1;
                                fault_next   = ERR_ADDR;
                            end else begin
                                pc_next = opnd_reg[1][AW:0];
                            end
                        end
                    end
                    OP_LT: begin
                        mem_we    = 1'b1;
                        mem_wdata = {63'd0, $signed(opnd_reg[0]) < $signed(opnd_reg[1])};
                    end
                    OP_EQ: begin
                        mem_we    = 1'b1;
                        mem_wdata = {63'd0, opnd_reg[0] == opnd_reg[1]};
                    end
                    default: begin
                        rb_next = rb_reg + opnd_reg[0];
                    end
                endcase
            end
            ST_MUL0: begin
                acc_next   = mul_p;
                state_next = ST_MUL1;
            end
            ST_MUL1: begin
                acc_next   = acc_reg + {mul_p[31:0], 32'd0};
                state_next = ST_MUL2;
            end
            ST_MUL2: begin
                mem_we     = 1'b1;
                mem_wdata  = acc_reg + {mul_p[31:0], 32'd0};
                pc_next    = pc_adv;
                state_next = ST_FIN;
            end
            ST_FIN: begin
                // Hold until the output register is free
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {2'd0, fault_reg, stopped_reg, res_wait_reg,
                                     res_taken_reg, res_value_reg, res_valid_reg};
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        mem_rdata_reg <= mem[mem_raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLR;
            clr_addr_reg <= '0;
            pc_reg       <= '0;
            rb_reg       <= '0;
            stopped_reg  <= 1'b0;
            fault_reg    <= ERR_NONE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            pc_reg       <= pc_next;
            rb_reg       <= rb_next;
            stopped_reg  <= stopped_next;
            fault_reg    <= fault_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg       <= req_next;
        val_reg       <= val_next;
        offered_reg   <= offered_next;
        word_reg      <= word_next;
        rem_reg       <= rem_next;
        fold_reg      <= fold_next;
        quo_reg       <= quo_next;
        q_reg         <= q_next;
        q2_reg        <= q2_next;
        op_reg        <= op_next;
        modes_reg     <= modes_next;
        nparam_reg    <= nparam_next;
        wr_idx_reg    <= wr_idx_next;
        k_reg         <= k_next;
        opnd_reg      <= opnd_next;
        acc_reg       <= acc_next;
        res_valid_reg <= res_valid_next;
        res_value_reg <= res_value_next;
        res_taken_reg <= res_taken_next;
        res_wait_reg  <= res_wait_next;
        m_tdata_reg   <= m_tdata_next;
    end

    // A nonzero fault code always comes with the stopped flag
    a_fault_stops: assert property (@(posedge aclk) disable iff (!aresetn)
        fault_reg != ERR_NONE |-> stopped_reg)
        else $error("fault code set without stopped flag");

    // A restart reports a running, fault-free processor
    a_restart_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_FIN && req_reg == REQ_RESTART |-> !stopped_reg && fault_reg == ERR_NONE)
        else $error("restart left stopped or fault state");

    // A stalled input instruction leaves the counter where it was
    a_wait_holds_pc: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_EXEC && op_reg == OP_IN && !offered_reg |=> $stable(pc_reg))
        else $error("counter moved on stalled input");

    // No transaction is taken while the store is still being cleared
    a_clear_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_CLR |-> !s_tready)
        else $error("input accepted during clearing pass");

endmodule
